// File: rtl/ndag_pkg.sv
package ndag_pkg;

	localparam int FIELD_W = 16;
	localparam int CNT_W   = 17;
	localparam int ADDR_W  = 32;
	localparam int OP_W    = 3;
	localparam int AXIS_W  = 2;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;
	localparam int REG_W   = 64;

	localparam logic [OP_W-1:0] OP_HOLD      = 3'd0;
	localparam logic [OP_W-1:0] OP_ADV_INNER = 3'd1;
	localparam logic [OP_W-1:0] OP_ADV_AXIS  = 3'd2;
	localparam logic [OP_W-1:0] OP_FINISH    = 3'd3;
	localparam logic [OP_W-1:0] OP_RESTART   = 3'd4;

	localparam logic [1:0] REG_DIM_COUNT = 2'd0;
	localparam logic [1:0] REG_ITER_EXT  = 2'd1;
	localparam logic [1:0] REG_IDX_EXT   = 2'd2;
	localparam logic [1:0] REG_IDX_OFF   = 2'd3;

	localparam logic [2:0]       DIM_COUNT_RST = 3'd1;
	localparam logic [REG_W-1:0] EXT_RST       = 64'h0001_0001_0001_0001;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [AXIS_W-1:0] axis;
	} ndag_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              in_range;
		logic [CNT_W-1:0]  axis_count;
	} ndag_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DONE
	} ndag_state_t;

	function automatic logic [FIELD_W-1:0] field16(input logic [REG_W-1:0] w,
			input logic [1:0] i);
		return w[FIELD_W*i +: FIELD_W];
	endfunction

endpackage

// File: rtl/nd_address_generator.sv
// Channel | Signals                         | Payload     | Accepted when
// req     | req_valid, req_ready, req       | ndag_req_t  | req_valid & req_ready
// rsp     | rsp_valid, rsp_ready, rsp       | ndag_rsp_t  | rsp_valid & rsp_ready
// config  | psel, penable, pwrite, paddr ...| 64-bit regs | psel & penable & pwrite
//
// The counter update happens in the accept cycle; then one multiply-add per dimension
// in use runs on a shared 32x16 multiplier.
// The result register frees the datapath: a new request is taken as soon as the
// multiply-add loop ends, while the previous result may still wait on rsp_ready.
// If the result register is still full at loop end, the block holds until it drains.
// Reset: counters cleared, dim_count 1, all bounds and extents 1, offsets 0.
module nd_address_generator
	import ndag_pkg::*;
#(
	parameter int DIM_SLOTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  ndag_req_t          req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ndag_rsp_t          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int IDX_W = (DIM_SLOTS > 1) ? $clog2(DIM_SLOTS) : 1;
	localparam logic [2:0] SLOTS3 = 3'(DIM_SLOTS);

	logic [2:0]       dim_count_q;
	logic [REG_W-1:0] iter_ext_q;
	logic [REG_W-1:0] idx_ext_q;
	logic [REG_W-1:0] idx_off_q;

	logic [CNT_W-1:0] cnt_q [DIM_SLOTS];
	logic [CNT_W-1:0] cnt_n [DIM_SLOTS];

	ndag_state_t      state_q, state_n;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] axis_q;
	logic [ADDR_W-1:0] acc_q;
	logic             valid_q;
	ndag_rsp_t        rsp_q;
	logic             rsp_valid_q;

	logic [2:0]       n_used;
	logic [IDX_W-1:0] last;
	logic [IDX_W-1:0] ax_eff;
	logic [IDX_W-1:0] start;
	logic             carry;
	logic             accept;
	logic             rsp_free;
	logic             load_mac;
	logic             load_acc;
	logic             cfg_wr;

	logic [FIELD_W-1:0]   ext_s;
	logic [FIELD_W-1:0]   off_s;
	logic [FIELD_W-1:0]   bnd_s;
	logic [CNT_W-1:0]     cnt_s;
	logic [CNT_W:0]       idx_sum;
	logic [CNT_W:0]       idx_eff;
	logic [ADDR_W-1:0]    prod;
	logic [ADDR_W-1:0]    acc_next;
	logic                 valid_next;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= DIM_COUNT_RST;
			iter_ext_q  <= EXT_RST;
			idx_ext_q   <= EXT_RST;
			idx_off_q   <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				REG_DIM_COUNT: dim_count_q <= pwdata[2:0];
				REG_ITER_EXT:  iter_ext_q  <= pwdata;
				REG_IDX_EXT:   idx_ext_q   <= pwdata;
				REG_IDX_OFF:   idx_off_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_DIM_COUNT: prdata = {61'b0, dim_count_q};
			REG_ITER_EXT:  prdata = iter_ext_q;
			REG_IDX_EXT:   prdata = idx_ext_q;
			REG_IDX_OFF:   prdata = idx_off_q;
			default:       prdata = '0;
		endcase
	end

	// ---------------- dimension and axis clamping ----------------
	always_comb begin
		if (dim_count_q == 3'd0) begin
			n_used = 3'd1;
		end else if (dim_count_q > SLOTS3) begin
			n_used = SLOTS3;
		end else begin
			n_used = dim_count_q;
		end
		last   = IDX_W'(n_used - 3'd1);
		ax_eff = ({1'b0, req.axis} >= n_used) ? last : IDX_W'(req.axis);
		start  = (req.operation == OP_ADV_INNER) ? last : ax_eff;
	end

	// ---------------- counter update for the incoming request ----------------
	always_comb begin
		cnt_n = cnt_q;
		carry = 1'b1;
		case (req.operation)
			OP_ADV_INNER, OP_ADV_AXIS: begin
				// outermost counter at its bound freezes the walk
				if (cnt_q[0] < {1'b0, field16(iter_ext_q, 2'd0)}) begin
					for (int i = DIM_SLOTS - 1; i >= 0; i--) begin
						if (carry && IDX_W'(i) <= start) begin
							if (i != 0 && ({1'b0, cnt_q[i]} + 18'd1) >=
									{2'b0, field16(iter_ext_q, 2'(i))}) begin
								cnt_n[i] = '0;
							end else begin
								cnt_n[i] = cnt_q[i] + CNT_W'(1);
								carry    = 1'b0;
							end
						end
					end
				end
			end
			OP_FINISH: begin
				cnt_n[0] = {1'b0, field16(iter_ext_q, 2'd0)} + CNT_W'(1);
			end
			OP_RESTART: begin
				for (int i = 0; i < DIM_SLOTS; i++) begin
					if (IDX_W'(i) <= last) begin
						cnt_n[i] = '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign accept = req_valid & req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM_SLOTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (accept) begin
			cnt_q <= cnt_n;
		end
	end

	// ---------------- shared multiply-add (Horner step) ----------------
	// only the low 32 bits of the product matter, the address wraps
	always_comb begin
		ext_s      = field16(idx_ext_q, 2'(step_q));
		off_s      = field16(idx_off_q, 2'(step_q));
		bnd_s      = field16(iter_ext_q, 2'(step_q));
		cnt_s      = cnt_q[step_q];
		idx_sum    = {1'b0, cnt_s} + {2'b0, off_s};
		idx_eff    = (idx_sum >= {2'b0, ext_s}) ? '0 : idx_sum;
		prod       = acc_q * {16'b0, ext_s};
		acc_next   = prod + {14'b0, idx_eff};
		valid_next = valid_q & (cnt_s < {1'b0, bnd_s});
	end

	// ---------------- sequencer ----------------
	assign rsp_free = ~rsp_valid_q | rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		req_ready = 1'b0;
		load_mac  = 1'b0;
		load_acc  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_n = ST_MAC;
				end
			end
			ST_MAC: begin
				if (step_q == last) begin
					if (rsp_free) begin
						load_mac = 1'b1;
						state_n  = ST_IDLE;
					end else begin
						state_n = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					load_acc = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q   <= '0;
			valid_q <= 1'b1;
			step_q  <= '0;
			axis_q  <= ax_eff;
		end else if (state_q == ST_MAC) begin
			acc_q   <= acc_next;
			valid_q <= valid_next;
			step_q  <= step_q + IDX_W'(1);
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_mac || load_acc) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_mac) begin
			rsp_q.address    <= acc_next;
			rsp_q.in_range   <= valid_next;
			rsp_q.axis_count <= cnt_q[axis_q];
		end else if (load_acc) begin
			rsp_q.address    <= acc_q;
			rsp_q.in_range   <= valid_q;
			rsp_q.axis_count <= cnt_q[axis_q];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- assertions ----------------
	a_accept_starts_loop: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MAC) && (step_q == '0))
		else $error("request accepted but multiply-add loop did not start at step 0");

	a_done_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> rsp_valid_q)
		else $error("result parked while output register is empty");

	a_outer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CNT_W'(1 << FIELD_W))
		else $error("outermost counter beyond finish value");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) && (step_q != last) |=> !accept)
		else $error("request accepted before address loop finished");

endmodule
